[sv/met_pkg.sv]
`timescale 1ns / 1ps

package met_pkg;

  // Field widths.
  localparam int PIX_W   = 10;
  localparam int CNT_W   = 16;
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 28;
  localparam int THR_W   = 36;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SQ_W    = 35;
  localparam int ACC_W   = 44;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] IDX_RE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_RE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_IM_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_IM_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_MAX_ITER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_ESC_THRESH = 3'd5;

  // Register values after reset: view of roughly -1.4 to +1.4, limit 100, bound 4.0.
  localparam logic signed [COORD_W-1:0] RST_RE_START   = -32'sd375809638;
  localparam logic signed [COORD_W-1:0] RST_RE_STEP    = 32'sd734003;
  localparam logic signed [COORD_W-1:0] RST_IM_START   = -32'sd375809638;
  localparam logic signed [COORD_W-1:0] RST_IM_STEP    = 32'sd734003;
  localparam logic [CNT_W-1:0]          RST_MAX_ITER   = 16'd100;
  localparam logic [THR_W-1:0]          RST_ESC_THRESH = 36'd1073741824;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Clamp a wide signed value into the Q4.28 range.
  function automatic coord_t sat_coord(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - acc_t'(1);
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end else begin
      return coord_t'(v);
    end
  endfunction

endpackage

[sv/met_in_if.sv]
`timescale 1ns / 1ps

interface met_in_if import met_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[sv/met_out_if.sv]
`timescale 1ns / 1ps

interface met_out_if import met_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_x;
  logic [PIX_W-1:0] out_y;
  logic [CNT_W-1:0] iteration_count;
  logic             escaped;

  modport source (output valid, output out_x, output out_y, output iteration_count,
                  output escaped, input ready);
  modport sink (input valid, input out_x, input out_y, input iteration_count,
                input escaped, output ready);
endinterface

[sv/met_mul.sv]
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module met_mul import met_pkg::*; (
  input  logic   clk,
  input  coord_t op_a,
  input  coord_t op_b,
  output prod_t  prod_r
);

  prod_t prod_nxt;

  assign prod_nxt = prod_t'(op_a) * prod_t'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[sv/mandelbrot_escape_time_core.sv]
// Mandelbrot escape-time core.
// A request on in_chan carries a pixel (pixel_x, pixel_y). The core maps it to
// c = start + pixel * step in Q4.28, iterates z = z*z + c from zero and returns
// one request on out_chan with the pixel echoed, the iteration count and the
// escaped flag. The cfg_ port writes the view, limit and threshold registers;
// the user writes it only while the core is idle; the core does not enforce it.
// One signed 32x32 multiplier with a registered product is shared by all the
// work: the pixel is mapped to c first, then each iteration steps through update
// z, square re, square im and compare while forming re*im for the next step.
// in_chan.ready rises together with out_chan.valid. The core works on one pixel
// at a time and takes the next only once the last is in the output register.
// in_chan.ready is high only while the sequencer is idle. A finished result sits
// in an output register, so a new pixel is accepted while out_chan stalls; if
// that pixel finishes before the old result is taken, the core holds it and
// waits. Reset (rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and loads the default view, limit and threshold registers.
`timescale 1ns / 1ps

module mandelbrot_escape_time_core import met_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  met_in_if.sink                in_chan,
  met_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting; multiplier forms px*re_step
  localparam logic [2:0] ST_MCI  = 3'd1;  // c_re from product; py*im_step
  localparam logic [2:0] ST_CI   = 3'd2;  // c_im from product; clear z
  localparam logic [2:0] ST_Z    = 3'd3;  // z update
  localparam logic [2:0] ST_R    = 3'd4;  // re*re
  localparam logic [2:0] ST_I    = 3'd5;  // keep re^2; im*im
  localparam logic [2:0] ST_C    = 3'd6;  // escape test; re*im for next step
  localparam logic [2:0] ST_DONE = 3'd7;  // hand result to the output register

  // Configuration registers.
  coord_t           re_start_r, re_step_r, im_start_r, im_step_r;
  logic [CNT_W-1:0] max_iter_r;
  logic [THR_W-1:0] thresh_r;

  // Working registers.
  logic [2:0]       state_r, state_nxt;
  logic [PIX_W-1:0] px_r, py_r;
  coord_t           cr_r, ci_r, zr_r, zi_r;
  logic [SQ_W-1:0]  zr2_r, zi2_r;
  logic [CNT_W-1:0] iter_r, cnt_r;
  logic             esc_r;

  // Output register.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_esc_r;

  // Shared multiplier.
  coord_t op_a, op_b;
  prod_t  prod_r;

  met_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  logic            in_fire;
  logic            out_load;
  acc_t            map_sum_re, map_sum_im;
  acc_t            cross_term, re_sum, im_sum;
  logic [SQ_W-1:0] sq_now;
  logic [THR_W-1:0] mag;
  logic            last_iter;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid           = out_valid_r;
  assign out_chan.out_x           = out_x_r;
  assign out_chan.out_y           = out_y_r;
  assign out_chan.iteration_count = out_cnt_r;
  assign out_chan.escaped         = out_esc_r;

  // Operand selection for the multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_IDLE: begin
        op_a = coord_t'({{(COORD_W-PIX_W){1'b0}}, in_chan.pixel_x});
        op_b = re_step_r;
      end
      ST_MCI: begin
        op_a = coord_t'({{(COORD_W-PIX_W){1'b0}}, py_r});
        op_b = im_step_r;
      end
      ST_R: begin
        op_a = zr_r;
        op_b = zr_r;
      end
      ST_I: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      ST_C: begin
        op_a = zr_r;
        op_b = zi_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Pixel mapping products are at most 42 bits wide, so they fit the sum width.
  assign map_sum_re = acc_t'(re_start_r) + acc_t'(prod_r[ACC_W-1:0]);
  assign map_sum_im = acc_t'(im_start_r) + acc_t'(prod_r[ACC_W-1:0]);

  // Cross term 2*re*im: the product shifted right by FRAC_W-1, floor rounding.
  assign cross_term = acc_t'($signed(prod_r[PROD_W-1:FRAC_W-1]));
  assign re_sum     = acc_t'({1'b0, zr2_r}) - acc_t'({1'b0, zi2_r}) + acc_t'(cr_r);
  assign im_sum     = cross_term + acc_t'(ci_r);

  // Squares are non-negative, so the shifted product is plain unsigned.
  assign sq_now    = prod_r[FRAC_W+SQ_W-1:FRAC_W];
  assign mag       = THR_W'({1'b0, zr2_r}) + THR_W'({1'b0, sq_now});
  assign last_iter = ({1'b0, iter_r} + (CNT_W+1)'(1)) == {1'b0, max_iter_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = ST_MCI;
      end
      ST_MCI: state_nxt = ST_CI;
      ST_CI: begin
        state_nxt = (max_iter_r == '0) ? ST_DONE : ST_Z;
      end
      ST_Z: state_nxt = ST_R;
      ST_R: state_nxt = ST_I;
      ST_I: state_nxt = ST_C;
      ST_C: begin
        state_nxt = ((mag > thresh_r) || last_iter) ? ST_DONE : ST_Z;
      end
      ST_DONE: if (out_load) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      re_start_r  <= RST_RE_START;
      re_step_r   <= RST_RE_STEP;
      im_start_r  <= RST_IM_START;
      im_step_r   <= RST_IM_STEP;
      max_iter_r  <= RST_MAX_ITER;
      thresh_r    <= RST_ESC_THRESH;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          IDX_RE_START:   re_start_r <= coord_t'(cfg_data[COORD_W-1:0]);
          IDX_RE_STEP:    re_step_r  <= coord_t'(cfg_data[COORD_W-1:0]);
          IDX_IM_START:   im_start_r <= coord_t'(cfg_data[COORD_W-1:0]);
          IDX_IM_STEP:    im_step_r  <= coord_t'(cfg_data[COORD_W-1:0]);
          IDX_MAX_ITER:   max_iter_r <= cfg_data[CNT_W-1:0];
          IDX_ESC_THRESH: thresh_r   <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_fire) begin
        px_r <= in_chan.pixel_x;
        py_r <= in_chan.pixel_y;
      end
      ST_MCI: cr_r <= sat_coord(map_sum_re);
      ST_CI: begin
        ci_r   <= sat_coord(map_sum_im);
        zr_r   <= '0;
        zi_r   <= '0;
        zr2_r  <= '0;
        zi2_r  <= '0;
        iter_r <= '0;
        cnt_r  <= '0;
        esc_r  <= 1'b0;
      end
      ST_Z: begin
        zr_r <= sat_coord(re_sum);
        zi_r <= sat_coord(im_sum);
      end
      ST_I: zr2_r <= sq_now;
      ST_C: begin
        zi2_r <= sq_now;
        if (mag > thresh_r) begin
          cnt_r <= iter_r;
          esc_r <= 1'b1;
        end else if (last_iter) begin
          cnt_r <= max_iter_r;
          esc_r <= 1'b0;
        end else begin
          iter_r <= iter_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_r   <= px_r;
      out_y_r   <= py_r;
      out_cnt_r <= cnt_r;
      out_esc_r <= esc_r;
    end
  end

endmodule
